FILE: rtl/ktah_pkg.sv
package ktah_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int INDEX_SLOTS = 1024;

	localparam int POS_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = $clog2(INDEX_SLOTS);
	localparam int KEY_W  = 32;
	localparam int NS_W   = 64;

	typedef enum logic [1:0] {
		REQ_CLEAR,
		REQ_LOAD,
		REQ_ADD,
		REQ_READ
	} req_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] entry;
	} slot_t;

	typedef struct packed {
		logic              sweep;
		logic              we;
		logic [SLOT_W-1:0] addr;
		slot_t             wdata;
	} idx_ctrl_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [NS_W-1:0]  total;
	} ent_t;

endpackage

FILE: rtl/ktah_index.sv
module ktah_index (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ktah_pkg::idx_ctrl_t  ctrl,
	output ktah_pkg::slot_t      rd_data,
	output logic                 busy
);

	ktah_pkg::slot_t                    mem [ktah_pkg::INDEX_SLOTS];
	ktah_pkg::slot_t                    rd_q;
	logic                               busy_q;
	logic [ktah_pkg::SLOT_W-1:0]        sweep_q;

	// sweep marks every slot empty, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			sweep_q <= '0;
		end else if (busy_q) begin
			sweep_q <= sweep_q + 1'b1;
			if (sweep_q == ktah_pkg::SLOT_W'(ktah_pkg::INDEX_SLOTS - 1)) begin
				busy_q <= 1'b0;
			end
		end else if (ctrl.sweep) begin
			busy_q  <= 1'b1;
			sweep_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[sweep_q] <= '0;
		end else if (ctrl.we) begin
			mem[ctrl.addr] <= ctrl.wdata;
		end
		rd_q <= mem[ctrl.addr];
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

FILE: rtl/keyed_time_accumulator_hash_core.sv
// Per-key time accumulator with an open-addressing hash index of 1024 slots over a table of
// up to 512 entries. Requests arrive one per beat and each gives exactly one result beat, in
// order. After reset the index is swept empty, one slot per cycle, so the input is not ready
// until that sweep ends; a clear request repeats the sweep and answers when it is done.
// The index is a memory with registered read, so each linear probe of it takes a wait
// state and a check state: a load or an add passes ST_PROBE_WAIT and ST_PROBE_CHK once per
// probe, an add whose key is found and a read in range pass ST_ENT_WAIT and ST_ENT_USE, and
// a refused load or an out-of-range read goes straight to ST_RESP. A new request is taken only
// from ST_IDLE, which is reached while a result may still wait in the output register.
module keyed_time_accumulator_hash_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// key, base total, running, start time, now, position, zero pad
	input  logic [239:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found, entry_key, total, entry_position, sample time, zero pad
	output logic [175:0] m_tdata,
	// status
	output logic [1:0]   m_tuser
);

	localparam int POS_W  = ktah_pkg::POS_W;
	localparam int CNT_W  = ktah_pkg::CNT_W;
	localparam int SLOT_W = ktah_pkg::SLOT_W;
	localparam int KEY_W  = ktah_pkg::KEY_W;
	localparam int NS_W   = ktah_pkg::NS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE_WAIT,
		ST_PROBE_CHK,
		ST_ENT_WAIT,
		ST_ENT_USE,
		ST_SWEEP,
		ST_RESP
	} state_t;

	state_t               state_q;
	ktah_pkg::req_t       req_q;
	logic [KEY_W-1:0]     key_q;
	logic [NS_W-1:0]      base_q;
	logic                 run_q;
	logic [NS_W-1:0]      start_q;
	logic [NS_W-1:0]      now_q;
	logic [NS_W-1:0]      delta_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    probes_q;
	logic [POS_W-1:0]     ent_addr_q;
	logic [CNT_W-1:0]     count_q;

	logic                 res_found_q;
	logic [KEY_W-1:0]     res_key_q;
	logic [NS_W-1:0]      res_total_q;
	logic [POS_W-1:0]     res_pos_q;
	logic [NS_W-1:0]      res_sample_q;
	logic [1:0]           res_status_q;

	logic                 out_valid_q;
	logic                 out_found_q;
	logic [KEY_W-1:0]     out_key_q;
	logic [NS_W-1:0]      out_total_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [NS_W-1:0]      out_sample_q;
	logic [1:0]           out_status_q;

	ktah_pkg::ent_t       ent_mem [ktah_pkg::TABLE_DEPTH];
	ktah_pkg::ent_t       ent_rd_q;
	ktah_pkg::ent_t       ent_wdata;
	logic                 ent_we;
	logic [NS_W-1:0]      ent_sum;

	ktah_pkg::idx_ctrl_t  idx_ctrl;
	ktah_pkg::slot_t      slot_rd;
	logic                 idx_busy;

	logic [KEY_W-1:0]     in_key;
	logic [NS_W-1:0]      in_base;
	logic                 in_run;
	logic [NS_W-1:0]      in_start;
	logic [NS_W-1:0]      in_now;
	logic [POS_W-1:0]     in_pos;
	ktah_pkg::req_t       in_req;
	logic                 accept;
	logic                 probe_last;
	logic                 key_hit;
	logic                 load_place;
	logic                 out_load;

	assign in_key   = s_tdata[31:0];
	assign in_base  = s_tdata[95:32];
	assign in_run   = s_tdata[96];
	assign in_start = s_tdata[160:97];
	assign in_now   = s_tdata[224:161];
	assign in_pos   = s_tdata[233:225];
	assign in_req   = ktah_pkg::req_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE) && !idx_busy;
	assign accept   = s_tvalid && s_tready;

	assign probe_last = probes_q == SLOT_W'(ktah_pkg::INDEX_SLOTS - 1);
	assign key_hit    = slot_rd.valid && (slot_rd.key == key_q)
		&& ({{(CNT_W-POS_W){1'b0}}, slot_rd.entry} < count_q);
	assign load_place = (state_q == ST_PROBE_CHK) && (req_q == ktah_pkg::REQ_LOAD)
		&& !slot_rd.valid;
	assign out_load   = (state_q == ST_RESP) && (!out_valid_q || m_tready);

	always_comb begin
		idx_ctrl             = '0;
		idx_ctrl.sweep       = accept && (in_req == ktah_pkg::REQ_CLEAR);
		idx_ctrl.addr        = slot_q;
		idx_ctrl.we          = load_place;
		idx_ctrl.wdata.valid = 1'b1;
		idx_ctrl.wdata.key   = key_q;
		idx_ctrl.wdata.entry = count_q[POS_W-1:0];
	end

	ktah_index u_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (idx_ctrl),
		.rd_data (slot_rd),
		.busy    (idx_busy)
	);

	assign ent_sum = ent_rd_q.total + delta_q;
	assign ent_we  = load_place
		|| ((state_q == ST_ENT_USE) && (req_q == ktah_pkg::REQ_ADD));

	always_comb begin
		if (req_q == ktah_pkg::REQ_LOAD) begin
			ent_wdata.key   = key_q;
			ent_wdata.total = base_q;
		end else begin
			ent_wdata.key   = ent_rd_q.key;
			ent_wdata.total = ent_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_addr_q] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[ent_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= ktah_pkg::REQ_CLEAR;
			key_q        <= '0;
			base_q       <= '0;
			run_q        <= 1'b0;
			start_q      <= '0;
			now_q        <= '0;
			delta_q      <= '0;
			slot_q       <= '0;
			probes_q     <= '0;
			ent_addr_q   <= '0;
			count_q      <= '0;
			res_found_q  <= 1'b0;
			res_key_q    <= '0;
			res_total_q  <= '0;
			res_pos_q    <= '0;
			res_sample_q <= '0;
			res_status_q <= ktah_pkg::STAT_OK;
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_key_q    <= '0;
			out_total_q  <= '0;
			out_pos_q    <= '0;
			out_sample_q <= '0;
			out_status_q <= ktah_pkg::STAT_OK;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			// elapsed time to add, settled before the entry is read back
			if (run_q && (now_q >= start_q)) begin
				delta_q <= now_q - start_q;
			end else begin
				delta_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q        <= in_req;
						key_q        <= in_key;
						base_q       <= in_base;
						run_q        <= in_run;
						start_q      <= in_start;
						now_q        <= in_now;
						slot_q       <= in_key[SLOT_W-1:0];
						probes_q     <= '0;
						res_found_q  <= 1'b0;
						res_key_q    <= in_key;
						res_total_q  <= '0;
						res_pos_q    <= '0;
						res_sample_q <= '0;
						res_status_q <= ktah_pkg::STAT_OK;
						unique case (in_req)
							ktah_pkg::REQ_CLEAR: begin
								count_q   <= '0;
								res_key_q <= '0;
								state_q   <= ST_SWEEP;
							end
							ktah_pkg::REQ_LOAD: begin
								ent_addr_q <= count_q[POS_W-1:0];
								if (count_q == CNT_W'(ktah_pkg::TABLE_DEPTH)) begin
									res_status_q <= ktah_pkg::STAT_FULL;
									state_q      <= ST_RESP;
								end else begin
									state_q <= ST_PROBE_WAIT;
								end
							end
							ktah_pkg::REQ_ADD: begin
								res_sample_q <= in_now;
								state_q      <= ST_PROBE_WAIT;
							end
							ktah_pkg::REQ_READ: begin
								ent_addr_q <= in_pos;
								res_pos_q  <= in_pos;
								if ({{(CNT_W-POS_W){1'b0}}, in_pos} < count_q) begin
									state_q <= ST_ENT_WAIT;
								end else begin
									res_key_q    <= '0;
									res_status_q <= ktah_pkg::STAT_RANGE;
									state_q      <= ST_RESP;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_PROBE_WAIT: begin
					state_q <= ST_PROBE_CHK;
				end
				ST_PROBE_CHK: begin
					if (req_q == ktah_pkg::REQ_LOAD) begin
						if (!slot_rd.valid) begin
							count_q     <= count_q + 1'b1;
							res_found_q <= 1'b1;
							res_total_q <= base_q;
							res_pos_q   <= count_q[POS_W-1:0];
							state_q     <= ST_RESP;
						end else if (probe_last) begin
							res_status_q <= ktah_pkg::STAT_FULL;
							state_q      <= ST_RESP;
						end else begin
							slot_q   <= slot_q + 1'b1;
							probes_q <= probes_q + 1'b1;
							state_q  <= ST_PROBE_WAIT;
						end
					end else begin
						if (!slot_rd.valid) begin
							state_q <= ST_RESP;
						end else if (key_hit) begin
							ent_addr_q <= slot_rd.entry;
							state_q    <= ST_ENT_WAIT;
						end else if (probe_last) begin
							state_q <= ST_RESP;
						end else begin
							slot_q   <= slot_q + 1'b1;
							probes_q <= probes_q + 1'b1;
							state_q  <= ST_PROBE_WAIT;
						end
					end
				end
				ST_ENT_WAIT: begin
					state_q <= ST_ENT_USE;
				end
				ST_ENT_USE: begin
					res_found_q <= 1'b1;
					res_pos_q   <= ent_addr_q;
					if (req_q == ktah_pkg::REQ_ADD) begin
						res_total_q <= ent_sum;
					end else begin
						res_key_q   <= ent_rd_q.key;
						res_total_q <= ent_rd_q.total;
					end
					state_q <= ST_RESP;
				end
				ST_SWEEP: begin
					if (!idx_busy) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						out_found_q  <= res_found_q;
						out_key_q    <= res_key_q;
						out_total_q  <= res_total_q;
						out_pos_q    <= res_pos_q;
						out_sample_q <= res_sample_q;
						out_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_sample_q, out_pos_q, out_total_q, out_key_q, out_found_q};
	assign m_tuser  = out_status_q;

endmodule
